// ===== rtl/sorted_priority_queue_defines.svh =====
// Assertion macros used by the one file that checks its own logic.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int unsigned DefaultQueueDepth = 16;
  localparam int unsigned PrioWidth = 16;
  localparam int unsigned PayloadWidth = 32;
  localparam int unsigned OccWidth = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [PrioWidth-1:0] prio;
    logic [PayloadWidth-1:0]     payload;
  } entry_t;

  typedef struct packed {
    logic                        ins;
    logic                        pop;
    logic signed [PrioWidth-1:0] prio;
    logic [PayloadWidth-1:0]     payload;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic   clk_i,
  input  wire ctrl_t  ctrl_i,
  input  wire logic   occupied_i,
  input  wire logic   left_lower_i,
  input  wire entry_t left_entry_i,
  input  wire entry_t right_entry_i,
  output logic        lower_o,
  output entry_t      entry_o
);

  entry_t entry_q, entry_d;

  // A free slot counts as lower so that an insert past all stored words lands at the tail.
  assign lower_o = !occupied_i || ($signed(entry_q.prio) < $signed(ctrl_i.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && lower_o) begin
      if (left_lower_i) begin
        entry_d = left_entry_i;
      end else begin
        entry_d.prio    = ctrl_i.prio;
        entry_d.payload = ctrl_i.payload;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Channel  | Dir | tdata (low bit up)                      | tuser
// s_axis   | in  | priority_req[15:0], payload[47:16]      | req_type
// m_axis   | out | out_priority[15:0], out_payload[47:16], | status[1:0]
//          |     | occupancy[52:48]                        |
// A request word is taken per cycle; its result is registered for the next cycle.
// A row of compare-and-shift cells moves stored entries as the request is accepted.
// rst_ni clears the entry count and the output valid flag; the store keeps no reset.
// A stalled result holds the input off only while the output register is full.
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefaultQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // priority_req, payload
  input  wire logic        s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // out_priority, out_payload, occupancy
  output logic [1:0]       m_axis_tuser    // status
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  entry_t          out_entry_q, out_entry_d;
  logic [CntW-1:0] out_count_q;

  logic   accept, full, empty;
  ctrl_t  ctrl;
  entry_t entries [QUEUE_DEPTH];
  logic   lower [QUEUE_DEPTH];

  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign ctrl.ins     = accept && (s_axis_tuser == REQ_INSERT) && !full;
  assign ctrl.pop     = accept && (s_axis_tuser == REQ_POP) && !empty;
  assign ctrl.prio    = s_axis_tdata[15:0];
  assign ctrl.payload = s_axis_tdata[47:16];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_lower;
    entry_t left_entry, right_entry;

    if (i == 0) begin : g_head
      assign left_lower = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_lower = lower[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (CntW'(i) < count_q),
      .left_lower_i  (left_lower),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .lower_o       (lower[i]),
      .entry_o       (entries[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    status_d    = ST_OK;
    out_entry_d = '0;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d     = count_q - CntW'(1);
      out_entry_d = entries[0];
    end
    if (s_axis_tuser == REQ_INSERT) begin
      if (full) status_d = ST_FULL;
    end else begin
      if (empty) status_d = ST_EMPTY;
    end

    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_entry_q <= out_entry_d;
      out_count_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, OccWidth'(out_count_q), out_entry_q.payload,
                          out_entry_q.prio};

  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(QUEUE_DEPTH))
  `SPQ_ASSERT(a_pop_count, clk_i, rst_ni,
    ctrl.pop |=> count_q == $past(count_q) - CntW'(1))
  `SPQ_ASSERT(a_full_refused, clk_i, rst_ni,
    accept && (s_axis_tuser == REQ_INSERT) && full |=>
      status_q == ST_FULL && count_q == $past(count_q))
  `SPQ_ASSERT(a_head_order, clk_i, rst_ni,
    count_q >= CntW'(2) |-> $signed(entries[0].prio) >= $signed(entries[1].prio))

endmodule

`default_nettype wire
